// File: design/assert_macros.svh
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GDRS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdrs assertion failed");

// Next-cycle implication.
`define GDRS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdrs assertion failed");

`endif

// File: design/gdrs_pkg.sv
package gdrs_pkg;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH     = 3'd0,
        REG_GRID_HEIGHT    = 3'd1,
        REG_DIFFUSION_COEF = 3'd2,
        REG_RESIDUE_GROWTH = 3'd3,
        REG_RESIDUE_KEEP   = 3'd4
    } t_reg_idx;

    localparam logic [10:0] RST_GRID_WIDTH  = 11'd1024;
    localparam logic [15:0] RST_GRID_HEIGHT = 16'd1024;
    localparam logic [16:0] RST_KEEP        = 17'd65536;

    localparam logic signed [39:0] SAT_MAX = 40'sh007FFFFFFF;
    localparam logic signed [39:0] SAT_MIN = -40'sh0080000000;

    typedef struct packed {
        logic signed [31:0] cell_level;
        logic signed [31:0] cell_residue;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] level_out;
        logic signed [31:0] residue_out;
        logic [9:0]         col_index;
        logic [15:0]        row_index;
        logic               frame_last;
    } t_out_item;

    // per-item control that rides along the pipeline
    typedef struct packed {
        logic        emit_prev;  // result for the row above
        logic        emit_cur;   // last row passes through as well
        logic        elig;       // row above may be gated
        logic        last_col;
        logic [9:0]  col;
        logic [15:0] row;
    } t_ctrl;

    typedef struct packed {
        t_ctrl              ctrl;
        logic signed [31:0] ctr;
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] up;
        logic signed [31:0] lev;
        logic signed [31:0] res;
        logic signed [31:0] pres;
    } t_win;

    typedef struct packed {
        t_ctrl              ctrl;
        logic signed [31:0] nl;
        logic               changed;
        logic signed [33:0] res_prev;  // rounded decay, not yet saturated
        logic signed [31:0] lev;
        logic signed [31:0] res_cur;
    } t_cell;

    typedef struct packed {
        logic out_full;
        logic pend_full;
    } t_ob_stat;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] y;
        if (x > SAT_MAX) begin
            y = 32'sh7FFFFFFF;
        end else if (x < SAT_MIN) begin
            y = -32'sh80000000;
        end else begin
            y = 32'(x);
        end
        return y;
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] x);
        return x[32] ? 33'(-x) : 33'(x);
    endfunction

endpackage

// File: design/gated_diffusion_residue_stencil_top.sv
// Throughput: one item per cycle while the output takes results; on the last row each item
// gives two results, one per cycle, and the input waits while the second one is parked.
// Pipeline: line stores (1) -> differences (2) -> sums/products (3) -> gate (4) -> level (5) -> out.
// Reset (sync, active low): counters, stage valids and output buffer clear, config registers
// take their reset values; the line stores are not cleared, and their contents are only used
// after the rows feeding them were written.
`include "assert_macros.svh"

module gated_diffusion_residue_stencil_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // cell stream in
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gdrs_pkg::t_in_item            i_in_item,
    // result stream out
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gdrs_pkg::t_out_item           o_out_item,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gdrs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // ---------------------------------------------------------------
    // Config registers: the user writes them only while the stream is quiet; not enforced.
    // ---------------------------------------------------------------
    logic [10:0] r_grid_width;
    logic [15:0] r_grid_height;
    logic [15:0] r_diff_coef;
    logic [30:0] r_growth;
    logic [16:0] r_keep;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= gdrs_pkg::RST_GRID_WIDTH;
            r_grid_height <= gdrs_pkg::RST_GRID_HEIGHT;
            r_diff_coef   <= '0;
            r_growth      <= '0;
            r_keep        <= gdrs_pkg::RST_KEEP;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                gdrs_pkg::REG_GRID_WIDTH:     r_grid_width  <= pwdata[10:0];
                gdrs_pkg::REG_GRID_HEIGHT:    r_grid_height <= pwdata[15:0];
                gdrs_pkg::REG_DIFFUSION_COEF: r_diff_coef   <= pwdata[15:0];
                gdrs_pkg::REG_RESIDUE_GROWTH: r_growth      <= pwdata[30:0];
                gdrs_pkg::REG_RESIDUE_KEEP:   r_keep        <= pwdata[16:0];
                default: ;  // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            gdrs_pkg::REG_GRID_WIDTH:     prdata = 32'(r_grid_width);
            gdrs_pkg::REG_GRID_HEIGHT:    prdata = 32'(r_grid_height);
            gdrs_pkg::REG_DIFFUSION_COEF: prdata = 32'(r_diff_coef);
            gdrs_pkg::REG_RESIDUE_GROWTH: prdata = 32'(r_growth);
            gdrs_pkg::REG_RESIDUE_KEEP:   prdata = 32'(r_keep);
            default:                      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front end: raster counters and line stores. The newest row is read
    // one column ahead so the center, left and right levels come out of
    // registers; the older row and the residue row are read in place.
    // ---------------------------------------------------------------
    logic               win_valid, win_ready;
    gdrs_pkg::t_win     win;

    gdrs_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_item        (i_in_item),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .o_valid       (win_valid),
        .i_ready       (win_ready),
        .o_win         (win)
    );

    // ---------------------------------------------------------------
    // Arithmetic: gradient test against the residue, D * laplacian with
    // round-half-up, residue decay products. Each stage stalls only when
    // the one after it is full.
    // ---------------------------------------------------------------
    logic               cell_valid, cell_ready;
    gdrs_pkg::t_cell    stn_cell;

    gdrs_stencil u_stencil (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (win_valid),
        .o_ready     (win_ready),
        .i_win       (win),
        .i_diff_coef (r_diff_coef),
        .i_keep      (r_keep),
        .o_valid     (cell_valid),
        .i_ready     (cell_ready),
        .o_cell      (stn_cell)
    );

    // ---------------------------------------------------------------
    // Output buffer: adds growth for changed cells, then holds up to two
    // results (row above, plus the last row passing through).
    // ---------------------------------------------------------------
    gdrs_pkg::t_ob_stat ob_stat;

    gdrs_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cell_valid),
        .o_ready  (cell_ready),
        .i_cell   (stn_cell),
        .i_growth (r_growth),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_item   (o_out_item),
        .o_stat   (ob_stat)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // the input can only be held off by a result waiting downstream
    `GDRS_ASSERT_IMP(a_stall_needs_out, i_clk, i_rst_n, !o_in_ready, o_out_valid)
    // a second result is never parked without a first one
    `GDRS_ASSERT_IMP(a_pend_has_out, i_clk, i_rst_n, ob_stat.pend_full, ob_stat.out_full)
    // after a parked second result, the output stays loaded
    `GDRS_ASSERT_NXT(a_pend_then_out, i_clk, i_rst_n, ob_stat.pend_full, ob_stat.out_full)

endmodule

// File: design/gdrs_line_buf.sv
module gdrs_line_buf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gdrs_pkg::t_in_item i_item,
    input  logic [10:0]       i_grid_width,
    input  logic [15:0]       i_grid_height,
    output logic              o_valid,
    input  logic              i_ready,
    output gdrs_pkg::t_win    o_win
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = CW + 12;

    logic [CW-1:0]      r_col;
    logic [15:0]        r_row;
    logic               r_v;
    gdrs_pkg::t_ctrl    r_ctrl;
    logic signed [31:0] r_lev, r_res, r_ctr, r_left, r_right, r_up, r_pres;

    logic signed [31:0] r_mem_l1 [MAX_WIDTH];
    logic signed [31:0] r_mem_l2 [MAX_WIDTH];
    logic signed [31:0] r_mem_rs [MAX_WIDTH];

    logic [WB-1:0]   w_ext, w_eff, c_ext;
    logic [15:0]     h_eff;
    logic            last_col, last_row, accept;
    logic [CW-1:0]   la;
    gdrs_pkg::t_ctrl ctrl;

    assign w_ext = WB'(i_grid_width);
    assign w_eff = (w_ext == '0) ? WB'(1) :
                   (w_ext > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : w_ext;
    assign c_ext = WB'(r_col);
    assign last_col = (c_ext + WB'(1)) >= w_eff;
    assign h_eff = (i_grid_height == '0) ? 16'd1 : i_grid_height;
    assign last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, h_eff};
    // lookahead: next column of the row above, or col 0 of this row at row end
    assign la = last_col ? '0 : r_col + CW'(1);

    assign o_ready = !r_v || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        ctrl.emit_prev = (r_row != '0);
        ctrl.emit_cur  = last_row;
        ctrl.elig      = (r_row >= 16'd2) && (r_row < h_eff);
        ctrl.last_col  = last_col;
        ctrl.col       = 10'(r_col);
        ctrl.row       = r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 16'd1;
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctrl <= ctrl;
            r_lev  <= i_item.cell_level;
            r_res  <= i_item.cell_residue;
            r_ctr  <= r_right;
            r_left <= r_ctr;
        end
    end

    // newest complete row; read ahead by one column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_l1[r_col] <= i_item.cell_level;
            r_right <= (la == r_col) ? i_item.cell_level : r_mem_l1[la];
        end
    end

    // row before that; read before write gives the up neighbor
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_l2[r_col] <= r_right;
            r_up <= r_mem_l2[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_rs[r_col] <= i_item.cell_residue;
            r_pres <= r_mem_rs[r_col];
        end
    end

    assign o_valid = r_v;
    always_comb begin
        o_win.ctrl  = r_ctrl;
        o_win.ctr   = r_ctr;
        o_win.left  = r_left;
        o_win.right = r_right;
        o_win.up    = r_up;
        o_win.lev   = r_lev;
        o_win.res   = r_res;
        o_win.pres  = r_pres;
    end

endmodule

// File: design/gdrs_stencil.sv
module gdrs_stencil (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gdrs_pkg::t_win  i_win,
    input  logic [15:0]     i_diff_coef,
    input  logic [16:0]     i_keep,
    output logic            o_valid,
    input  logic            i_ready,
    output gdrs_pkg::t_cell o_cell
);

    // stage 2: differences, laplacian, residue products
    logic               r2_v;
    gdrs_pkg::t_ctrl    r2_ctrl;
    logic signed [32:0] r2_dl, r2_dr, r2_du, r2_dd;
    logic signed [34:0] r2_lap;
    logic signed [49:0] r2_pp, r2_rp;
    logic signed [31:0] r2_ctr, r2_lev, r2_pres;
    // stage 3: gradient sum, D*lap, rounded residues
    logic               r3_v;
    gdrs_pkg::t_ctrl    r3_ctrl;
    logic [34:0]        r3_grad;
    logic signed [51:0] r3_lp;
    logic signed [33:0] r3_r1, r3_r2;  // keep above one can push these past 32 bits
    logic signed [31:0] r3_ctr, r3_lev, r3_pres;
    // stage 4: gate decision, rounded kick
    logic               r4_v;
    gdrs_pkg::t_ctrl    r4_ctrl;
    logic               r4_gate;
    logic signed [35:0] r4_kick;
    logic signed [33:0] r4_r1, r4_r2;
    logic signed [31:0] r4_ctr, r4_lev;
    // stage 5: new level
    logic               r5_v;
    gdrs_pkg::t_cell    r5_cell;

    logic rdy2, rdy3, rdy4, rdy5;
    logic signed [32:0] c33;
    logic signed [36:0] sum5;
    logic signed [31:0] sat5;

    assign rdy5 = !r5_v || i_ready;
    assign rdy4 = !r4_v || rdy5;
    assign rdy3 = !r3_v || rdy4;
    assign rdy2 = !r2_v || rdy3;
    assign o_ready = rdy2;

    assign c33  = 33'(i_win.ctr);
    assign sum5 = 37'(r4_ctr) + 37'(r4_kick);
    assign sat5 = gdrs_pkg::sat32(40'(sum5));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (rdy2) r2_v <= i_valid;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
            if (rdy5) r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ctrl <= i_win.ctrl;
            r2_dl   <= c33 - 33'(i_win.left);
            r2_dr   <= c33 - 33'(i_win.right);
            r2_du   <= c33 - 33'(i_win.up);
            r2_dd   <= c33 - 33'(i_win.lev);
            r2_lap  <= 35'(i_win.left) + 35'(i_win.right) + 35'(i_win.up)
                     + 35'(i_win.lev) - (35'(i_win.ctr) <<< 2);
            r2_pp   <= 50'(i_win.pres) * 50'($signed({1'b0, i_keep}));
            r2_rp   <= 50'(i_win.res) * 50'($signed({1'b0, i_keep}));
            r2_ctr  <= i_win.ctr;
            r2_lev  <= i_win.lev;
            r2_pres <= i_win.pres;
        end
        if (rdy3) begin
            r3_ctrl <= r2_ctrl;
            r3_grad <= 35'(gdrs_pkg::abs33(r2_dl)) + 35'(gdrs_pkg::abs33(r2_dr))
                     + 35'(gdrs_pkg::abs33(r2_du)) + 35'(gdrs_pkg::abs33(r2_dd));
            r3_lp   <= 52'(r2_lap) * 52'($signed({1'b0, i_diff_coef}));
            // round to nearest, ties up: floor((x + half) / 2^16)
            r3_r1   <= 34'((r2_pp + 50'sd32768) >>> 16);
            r3_r2   <= 34'((r2_rp + 50'sd32768) >>> 16);
            r3_ctr  <= r2_ctr;
            r3_lev  <= r2_lev;
            r3_pres <= r2_pres;
        end
        if (rdy4) begin
            r4_ctrl <= r3_ctrl;
            r4_gate <= r3_ctrl.elig && ($signed({1'b0, r3_grad}) > 36'(r3_pres));
            r4_kick <= 36'((r3_lp + 52'sd32768) >>> 16);
            r4_r1   <= r3_r1;
            r4_r2   <= r3_r2;
            r4_ctr  <= r3_ctr;
            r4_lev  <= r3_lev;
        end
        if (rdy5) begin
            r5_cell.ctrl     <= r4_ctrl;
            r5_cell.nl       <= r4_gate ? sat5 : r4_ctr;
            r5_cell.changed  <= r4_gate && (sat5 != r4_ctr);
            r5_cell.res_prev <= r4_r1;
            r5_cell.lev      <= r4_lev;
            r5_cell.res_cur  <= gdrs_pkg::sat32(40'(r4_r2));
        end
    end

    assign o_valid = r5_v;
    assign o_cell  = r5_cell;

endmodule

// File: design/gdrs_out.sv
module gdrs_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gdrs_pkg::t_cell    i_cell,
    input  logic [30:0]        i_growth,
    output logic               o_valid,
    input  logic               i_ready,
    output gdrs_pkg::t_out_item o_item,
    output gdrs_pkg::t_ob_stat o_stat
);

    logic                r_ov, r_pv;
    gdrs_pkg::t_out_item r_out, r_pend;
    gdrs_pkg::t_out_item res_a, res_b;
    logic                take, drain, has, both;
    logic signed [39:0]  grow;

    assign grow = i_cell.changed ? $signed({9'b0, i_growth}) : 40'sd0;

    always_comb begin
        res_a.level_out   = i_cell.nl;
        res_a.residue_out = gdrs_pkg::sat32(40'(i_cell.res_prev) + grow);
        res_a.col_index   = i_cell.ctrl.col;
        res_a.row_index   = i_cell.ctrl.row - 16'd1;
        res_a.frame_last  = 1'b0;
        res_b.level_out   = i_cell.lev;
        res_b.residue_out = i_cell.res_cur;
        res_b.col_index   = i_cell.ctrl.col;
        res_b.row_index   = i_cell.ctrl.row;
        res_b.frame_last  = i_cell.ctrl.last_col;
    end

    assign has   = i_cell.ctrl.emit_prev || i_cell.ctrl.emit_cur;
    assign both  = i_cell.ctrl.emit_prev && i_cell.ctrl.emit_cur;
    assign o_ready = !r_pv && (!r_ov || i_ready);
    assign take  = i_valid && o_ready;
    assign drain = r_ov && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else if (take) begin
            r_ov <= has;
            r_pv <= both;
        end else if (drain) begin
            r_ov <= r_pv;
            r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && has) begin
            r_out <= i_cell.ctrl.emit_prev ? res_a : res_b;
            if (both) begin
                r_pend <= res_b;
            end
        end else if (drain && r_pv) begin
            r_out <= r_pend;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign o_stat.out_full  = r_ov;
    assign o_stat.pend_full = r_pv;

endmodule

// File: verif/gated_diffusion_residue_stencil_top_tb.sv
module gated_diffusion_residue_stencil_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 1024;
    localparam int CYCLE_LIMIT = 400000;

    // Scoreboard: keeps its own copy of the line stores, counters and registers,
    // predicts the results each accepted cell releases, and checks them in order.
    class stencil_scoreboard;
        int          lvl_rows[2*MAXW];
        int          res_row[MAXW];
        int unsigned col_cnt, row_cnt;
        int unsigned width_reg, height_reg, coef_reg, growth_reg, keep_reg;
        gdrs_pkg::t_out_item expected_cells[$];
        int          n_errors, n_checked, n_gated;

        function new();
            foreach (lvl_rows[k]) lvl_rows[k] = 0;
            foreach (res_row[k]) res_row[k] = 0;
            col_cnt = 0; row_cnt = 0;
            width_reg = 1024; height_reg = 1024; coef_reg = 0;
            growth_reg = 0; keep_reg = 65536;
            n_errors = 0; n_checked = 0; n_gated = 0;
        endfunction

        function void set_reg(gdrs_pkg::t_reg_idx idx, int unsigned v);
            unique case (idx)
                gdrs_pkg::REG_GRID_WIDTH:     width_reg  = v & 32'h7FF;
                gdrs_pkg::REG_GRID_HEIGHT:    height_reg = v & 32'hFFFF;
                gdrs_pkg::REG_DIFFUSION_COEF: coef_reg   = v & 32'hFFFF;
                gdrs_pkg::REG_RESIDUE_GROWTH: growth_reg = v & 32'h7FFF_FFFF;
                gdrs_pkg::REG_RESIDUE_KEEP:   keep_reg   = v & 32'h1FFFF;
                default: ;
            endcase
        endfunction

        // divide by 2^16, nearest, ties upward
        function longint q16_round(longint x);
            return (x + 32768) >>> 16;
        endfunction

        function int clip32(longint x);
            if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (x < -64'sd2147483648) return 32'h8000_0000;
            return int'(x);
        endfunction

        function int decay_residue(longint r, bit changed);
            longint v;
            v = q16_round(r * longint'(keep_reg));
            if (changed) v += longint'(growth_reg);
            return clip32(v);
        endfunction

        function longint adiff(longint a, longint b);
            return a >= b ? a - b : b - a;
        endfunction

        function void note_cell(gdrs_pkg::t_in_item it);
            int unsigned w, h, c, r, cur, prv;
            longint lev, res, up, pres, ctr, nl, left, right, grad, lap;
            bit last_row, last_col, changed;
            gdrs_pkg::t_out_item o;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > MAXW) w = MAXW;
            h = (height_reg != 0) ? height_reg : 1;
            c = col_cnt; r = row_cnt;
            cur = (r & 1) * MAXW;
            prv = ((r + 1) & 1) * MAXW;
            lev = longint'(it.cell_level);
            res = longint'(it.cell_residue);
            last_row = (r + 1 >= h);
            last_col = (c + 1 >= w);
            up   = longint'(lvl_rows[cur + c]);
            pres = longint'(res_row[c]);
            lvl_rows[cur + c] = int'(lev);
            res_row[c] = int'(res);
            if (r >= 1) begin
                ctr = longint'(lvl_rows[prv + c]);
                nl = ctr;
                changed = 0;
                if (r >= 2 && r < h) begin
                    // edge columns wrap along the flat raster index
                    if (c == 0)
                        left = (w == 1) ? up : longint'(lvl_rows[cur + w - 1]);
                    else
                        left = longint'(lvl_rows[prv + c - 1]);
                    right = last_col ? longint'(lvl_rows[cur])
                                     : longint'(lvl_rows[prv + c + 1]);
                    grad = adiff(ctr, left) + adiff(ctr, right)
                         + adiff(ctr, up) + adiff(ctr, lev);
                    if (grad > pres) begin
                        lap = left + right + up + lev - 4 * ctr;
                        nl = clip32(ctr + q16_round(lap * longint'(coef_reg)));
                        changed = (nl != ctr);
                        n_gated++;
                    end
                end
                o.level_out   = int'(nl);
                o.residue_out = decay_residue(pres, changed);
                o.col_index   = c[9:0];
                o.row_index   = 16'(r - 1);
                o.frame_last  = 1'b0;
                expected_cells.push_back(o);
            end
            if (last_row) begin
                o.level_out   = int'(lev);
                o.residue_out = decay_residue(res, 1'b0);
                o.col_index   = c[9:0];
                o.row_index   = r[15:0];
                o.frame_last  = last_col;
                expected_cells.push_back(o);
            end
            if (last_col) begin
                col_cnt = 0;
                row_cnt = last_row ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check_result(gdrs_pkg::t_out_item got);
            gdrs_pkg::t_out_item e;
            if (expected_cells.size() == 0) begin
                $error("unexpected result: level=%h residue=%h", got.level_out,
                       got.residue_out);
                n_errors++;
                return;
            end
            e = expected_cells.pop_front();
            n_checked++;
            if (got.level_out !== e.level_out) begin
                $error("level_out: expected %h, got %h", e.level_out, got.level_out);
                n_errors++;
            end
            if (got.residue_out !== e.residue_out) begin
                $error("residue_out: expected %h, got %h", e.residue_out, got.residue_out);
                n_errors++;
            end
            if (got.col_index !== e.col_index) begin
                $error("col_index: expected %0d, got %0d", e.col_index, got.col_index);
                n_errors++;
            end
            if (got.row_index !== e.row_index) begin
                $error("row_index: expected %0d, got %0d", e.row_index, got.row_index);
                n_errors++;
            end
            if (got.frame_last !== e.frame_last) begin
                $error("frame_last: expected %0d, got %0d", e.frame_last, got.frame_last);
                n_errors++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    gdrs_pkg::t_in_item            i_in_item;
    logic                          o_out_valid;
    logic                          i_out_ready;
    gdrs_pkg::t_out_item           o_out_item;
    logic                          psel, penable, pwrite;
    logic [gdrs_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    stencil_scoreboard sb = new();

    // knobs shared by the stimulus and the receiver
    bit idle_on;         // random bursts of idling on both sides
    int sink_hold;       // long receiver hold-off, counted down by the receiver
    int cells_sent;
    int cycle_cnt;

    gated_diffusion_residue_stencil_top #(.MAX_WIDTH(MAXW)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Handshake monitors. Signals read here still hold their pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_cell(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    // Receiver: long hold-off on request, otherwise short random stalls.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            i_out_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // One APB write: setup cycle, then access cycle; the predictor follows along.
    task automatic reg_write(gdrs_pkg::t_reg_idx idx, int unsigned v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gdrs_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_grid(int unsigned w, int unsigned h, int unsigned d,
                            int unsigned g, int unsigned k);
        reg_write(gdrs_pkg::REG_GRID_WIDTH, w);
        reg_write(gdrs_pkg::REG_GRID_HEIGHT, h);
        reg_write(gdrs_pkg::REG_DIFFUSION_COEF, d);
        reg_write(gdrs_pkg::REG_RESIDUE_GROWTH, g);
        reg_write(gdrs_pkg::REG_RESIDUE_KEEP, k);
    endtask

    // Offer one item; valid stays up until the block takes it.
    task automatic send_cell(int lev, int res);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item.cell_level   <= lev;
        i_in_item.cell_residue <= res;
        do @(posedge i_clk); while (!o_in_ready);
        cells_sent++;
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_cells.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Mostly small levels so the stencil math stays meaningful; some extremes.
    task automatic send_random_cell();
        int lev, res;
        case ($urandom_range(0, 9))
            0: begin lev = $urandom(); res = $urandom(); end
            1: begin
                lev = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                res = $urandom_range(0, 1) ? 32'h8000_0000 : $urandom_range(0, 32'h3_0000);
            end
            default: begin
                lev = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
                res = int'($urandom_range(0, 32'h20_0000)) - 32'sh1_0000;
            end
        endcase
        send_cell(lev, res);
    endtask

    function automatic int unsigned eff_w(int unsigned w);
        return (w == 0) ? 1 : (w > MAXW ? MAXW : w);
    endfunction

    function automatic int unsigned eff_h(int unsigned h);
        return (h == 0) ? 1 : h;
    endfunction

    initial begin
        int unsigned w, h, frames, phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        idle_on = 1'b1;
        sink_hold = 0;
        cells_sent = 0;
        cycle_cnt = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 3x3 frame of saturating levels, full coefficient, max growth.
        set_grid(3, 3, 16'hFFFF, 32'h7FFF_FFFF, 65536);
        for (int k = 0; k < 9; k++)
            send_cell((k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h8000_0000);
        wait_drained();
        // Keep field at its top value, zero coefficient, residues at both ends.
        set_grid(3, 3, 0, 0, 32'h1FFFF);
        for (int k = 0; k < 9; k++)
            send_cell(k * 32'h1_0000 - 32'sh3_0000,
                      (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
        wait_drained();
        // Zero width and zero height: each cell is its own frame.
        set_grid(0, 0, 16'h8000, 32'h1_0000, 0);
        for (int k = 0; k < 3; k++) send_cell(32'h1234_5678, -32'sh10);
        wait_drained();
        // Two rows: nothing is gated.
        set_grid(2, 2, 16'h8000, 32'h1_0000, 65536);
        for (int k = 0; k < 4; k++) send_cell(k * 32'h4_0000, -1);
        wait_drained();
        // Single column: left neighbor is the cell above.
        set_grid(1, 3, 16'h4000, 32'h2_0000, 16'h8000);
        for (int k = 0; k < 3; k++) send_cell((k == 1) ? 32'h10_0000 : 0, 0);
        wait_drained();

        // Random geometry and coefficients, whole frames per setting.
        phase = 0;
        while (cells_sent < 400) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            set_grid(w, h, $urandom_range(0, 16'hFFFF), $urandom() & 32'h7FFF_FFFF,
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32'h1FFFF)
                                                 : $urandom_range(0, 65536));
            frames = $urandom_range(1, 2);
            if (phase == 2) sink_hold = 150; // block fills up and stalls its input
            if (cells_sent > 340) idle_on = 1'b0;
            for (int f = 0; f < frames; f++)
                for (int k = 0; k < eff_w(w) * eff_h(h); k++) send_random_cell();
            wait_drained();
            phase++;
        end

        // Tallest frame, left unfinished at the end of the run.
        set_grid(4, 16'hFFFF, 16'h2000, 32'h1_0000, 65536);
        for (int k = 0; k < 16; k++) send_random_cell();
        wait_drained();

        $display("Covered %0d cells, %0d results checked, %0d gated updates",
                 cells_sent, sb.n_checked, sb.n_gated);
        if (sb.n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/gdrs_pkg.sv
design/gdrs_line_buf.sv
design/gdrs_stencil.sv
design/gdrs_out.sv
design/gated_diffusion_residue_stencil_top.sv
verif/gated_diffusion_residue_stencil_top_tb.sv
